// ===== design/ffba_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the first-fit block allocator
// no dependencies; used by ffba_cell and first_fit_block_allocator

package ffba_pkg;

	localparam int OFF_W   = 40;
	localparam int CAP_W   = 32;
	localparam int SIZE_W  = 32;
	localparam int LIVE_W  = 41;
	localparam int CNT_W   = 32;
	localparam int ST_W    = 2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_REJECT    = 2'd1;
	localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic              func;
		logic [SIZE_W-1:0] request_size;
		logic [OFF_W-1:0]  release_offset;
		logic [CAP_W-1:0]  release_capacity;
		logic              release_valid;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [OFF_W-1:0]  block_offset;
		logic [CAP_W-1:0]  block_capacity;
		logic [SIZE_W-1:0] block_size;
		logic [LIVE_W-1:0] live_bytes;
		logic [CNT_W-1:0]  alloc_count;
	} rsp_t;

	// broadcast control from the sequencer to every cell of the list
	typedef struct packed {
		logic              fit_en;
		logic [SIZE_W-1:0] size;
		logic              remove;
		logic              append;
		logic [OFF_W-1:0]  new_off;
		logic [CAP_W-1:0]  new_cap;
	} cell_ctrl_t;

endpackage

// ===== design/ffba_cell.sv =====
`timescale 1ns / 1ps
// one slot of the free list: holds a block, compares it against the request size
// and shifts from its right-hand neighbour on removal; depends on ffba_pkg

module ffba_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ffba_pkg::cell_ctrl_t      ctrl,
	input  logic                      hit_in,
	input  logic                      prev_occ,
	input  logic                      next_occ,
	input  logic [ffba_pkg::OFF_W-1:0] next_off,
	input  logic [ffba_pkg::CAP_W-1:0] next_cap,
	input  logic [ffba_pkg::OFF_W-1:0] sel_off_in,
	input  logic [ffba_pkg::CAP_W-1:0] sel_cap_in,
	output logic                      occ,
	output logic [ffba_pkg::OFF_W-1:0] off,
	output logic [ffba_pkg::CAP_W-1:0] cap,
	output logic                      hit_out,
	output logic [ffba_pkg::OFF_W-1:0] sel_off_out,
	output logic [ffba_pkg::CAP_W-1:0] sel_cap_out
);
	import ffba_pkg::*;

	logic             occ_q;
	logic             fit_q;
	logic [OFF_W-1:0] off_q;
	logic [CAP_W-1:0] cap_q;
	logic             first;
	logic             shift;
	logic             load;

	// first fitting slot in list order
	assign first   = fit_q & ~hit_in;
	assign hit_out = hit_in | fit_q;
	assign shift   = ctrl.remove & hit_out;
	// append lands in the first empty slot
	assign load    = ctrl.append & ~occ_q & prev_occ;

	assign sel_off_out = first ? off_q : sel_off_in;
	assign sel_cap_out = first ? cap_q : sel_cap_in;
	assign occ = occ_q;
	assign off = off_q;
	assign cap = cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			fit_q <= 1'b0;
		end else begin
			if (ctrl.fit_en) begin
				fit_q <= occ_q & (cap_q >= ctrl.size);
			end
			if (shift) begin
				occ_q <= next_occ;
			end else if (load) begin
				occ_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			off_q <= next_off;
			cap_q <= next_cap;
		end else if (load) begin
			off_q <= ctrl.new_off;
			cap_q <= ctrl.new_cap;
		end
	end

endmodule

// ===== design/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// first-fit block allocator: request sequencer, region/live/count registers and
// the chain of ffba_cell slots forming the free list; depends on ffba_pkg, ffba_cell
// a result is registered when the exec state completes the request accepted in idle; the cells register
// their size compare at accept, the first-fit chain selects and shifts the list next
// a new request is taken only once the last has completed; a waiting result holds back only completion
// reset clears the free list occupancy and fit flags, region end, live bytes, count, store_ready and rsp_valid

module first_fit_block_allocator #(
	parameter int FREE_SLOTS  = 16,
	parameter int REGION_BITS = 40
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic            cfg_wr_data,
	input  logic            req_valid,
	output logic            req_ready,
	input  ffba_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ffba_pkg::rsp_t  rsp
);
	import ffba_pkg::*;

	localparam int END_W = REGION_BITS + 1;
	localparam int SUM_W = ((END_W > SIZE_W + 1) ? END_W : SIZE_W + 1) + 1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t            state_q;
	req_t              req_q;
	logic              store_ready_q;
	logic [END_W-1:0]  region_end_q;
	logic [LIVE_W-1:0] live_q;
	logic [CNT_W-1:0]  count_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	cell_ctrl_t        ctrl;
	logic              accept;
	logic              done;

	logic              hit_c  [0:FREE_SLOTS];
	logic [OFF_W-1:0]  sel_off_c [0:FREE_SLOTS];
	logic [CAP_W-1:0]  sel_cap_c [0:FREE_SLOTS];
	logic              occ_c  [0:FREE_SLOTS-1];
	logic [OFF_W-1:0]  off_c  [0:FREE_SLOTS-1];
	logic [CAP_W-1:0]  cap_c  [0:FREE_SLOTS-1];

	logic              hit;
	logic              full;
	logic [SUM_W-1:0]  end_sum;
	logic              exhausted;
	logic [LIVE_W:0]   live_add;
	logic [LIVE_W-1:0] live_sub;
	logic [LIVE_W-1:0] cap_ext;
	logic [CAP_W-1:0]  grant_cap;

	rsp_t              rsp_nxt;
	logic [END_W-1:0]  region_end_nxt;
	logic [LIVE_W-1:0] live_nxt;
	logic [CNT_W-1:0]  count_nxt;
	logic              do_remove;
	logic              do_append;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid & req_ready;
	assign done      = (state_q == S_EXEC) & (~rsp_valid_q | rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign ctrl.fit_en  = accept;
	assign ctrl.size    = req.request_size;
	assign ctrl.remove  = done & do_remove;
	assign ctrl.append  = done & do_append;
	assign ctrl.new_off = req_q.release_offset;
	assign ctrl.new_cap = req_q.release_capacity;

	assign hit_c[0]     = 1'b0;
	assign sel_off_c[0] = '0;
	assign sel_cap_c[0] = '0;

	for (genvar i = 0; i < FREE_SLOTS; i++) begin : g_cell
		logic             prev_occ;
		logic             next_occ;
		logic [OFF_W-1:0] next_off;
		logic [CAP_W-1:0] next_cap;

		if (i == 0) begin : g_head
			assign prev_occ = 1'b1;
		end else begin : g_body
			assign prev_occ = occ_c[i-1];
		end

		if (i == FREE_SLOTS - 1) begin : g_tail
			assign next_occ = 1'b0;
			assign next_off = '0;
			assign next_cap = '0;
		end else begin : g_link
			assign next_occ = occ_c[i+1];
			assign next_off = off_c[i+1];
			assign next_cap = cap_c[i+1];
		end

		ffba_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.hit_in      (hit_c[i]),
			.prev_occ    (prev_occ),
			.next_occ    (next_occ),
			.next_off    (next_off),
			.next_cap    (next_cap),
			.sel_off_in  (sel_off_c[i]),
			.sel_cap_in  (sel_cap_c[i]),
			.occ         (occ_c[i]),
			.off         (off_c[i]),
			.cap         (cap_c[i]),
			.hit_out     (hit_c[i+1]),
			.sel_off_out (sel_off_c[i+1]),
			.sel_cap_out (sel_cap_c[i+1])
		);
	end

	assign hit  = hit_c[FREE_SLOTS];
	assign full = occ_c[FREE_SLOTS-1];

	// fresh block end against the region limit
	assign end_sum   = SUM_W'(region_end_q) + SUM_W'(req_q.request_size);
	assign exhausted = end_sum > (SUM_W'(1) << REGION_BITS);

	assign grant_cap = hit ? sel_cap_c[FREE_SLOTS] : req_q.request_size;
	assign cap_ext   = LIVE_W'(req_q.func == FUNC_ALLOC ? grant_cap : req_q.release_capacity);
	assign live_add  = {1'b0, live_q} + {1'b0, cap_ext};
	// live bytes never drop below zero
	assign live_sub  = live_q - ((live_q < cap_ext) ? live_q : cap_ext);

	always_comb begin
		rsp_nxt        = '0;
		rsp_nxt.status = ST_REJECT;
		region_end_nxt = region_end_q;
		live_nxt       = live_q;
		count_nxt      = count_q;
		do_remove      = 1'b0;
		do_append      = 1'b0;
		if (req_q.func == FUNC_ALLOC) begin
			if (store_ready_q && req_q.request_size != '0) begin
				if (hit || !exhausted) begin
					rsp_nxt.status         = ST_OK;
					rsp_nxt.block_capacity = grant_cap;
					rsp_nxt.block_size     = req_q.request_size;
					live_nxt  = live_add[LIVE_W] ? '1 : live_add[LIVE_W-1:0];
					count_nxt = count_q + CNT_W'(1);
					if (hit) begin
						rsp_nxt.block_offset = sel_off_c[FREE_SLOTS];
						do_remove            = 1'b1;
					end else begin
						rsp_nxt.block_offset = OFF_W'(region_end_q);
						region_end_nxt       = END_W'(end_sum);
					end
				end else begin
					rsp_nxt.status = ST_EXHAUSTED;
				end
			end
		end else if (req_q.release_valid) begin
			if (full) begin
				rsp_nxt.status = ST_FULL;
			end else begin
				rsp_nxt.status = ST_OK;
				live_nxt       = live_sub;
				do_append      = 1'b1;
			end
		end
		rsp_nxt.live_bytes  = live_nxt;
		rsp_nxt.alloc_count = count_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			store_ready_q <= 1'b0;
			region_end_q  <= '0;
			live_q        <= '0;
			count_q       <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				store_ready_q <= cfg_wr_data;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (done) begin
						state_q      <= S_IDLE;
						region_end_q <= region_end_nxt;
						live_q       <= live_nxt;
						count_q      <= count_nxt;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (done) begin
			rsp_q <= rsp_nxt;
		end
	end

endmodule
